### rtl/twf_pkg.sv
// Shared constants, types and the quarter-wave sine table of the wow and flutter modulator.
package twf_pkg;

  localparam int SampleBits   = 16;
  localparam int PhaseBits    = 32;
  localparam int SineAddrBits = 8;
  localparam int MaxChannels  = 8;

  localparam int RomN      = 1 << SineAddrBits;
  localparam int DataW     = ((SampleBits + 7) / 8) * 8;
  localparam int GainW     = 18;
  localparam int MulW      = (SampleBits > GainW) ? SampleBits : GainW;
  localparam int ProdW     = 2 * MulW;
  localparam int NoiseShift = 31 - SampleBits;
  localparam int NoiseW    = SampleBits + 2;
  localparam int AccW      = SampleBits + 4;
  localparam int SumW      = 20;
  localparam int PosW      = 3;
  localparam int CountW    = 4;
  localparam int CfgW      = 32;
  localparam int CfgIdxW   = 3;

  localparam logic [31:0] LfsrTaps  = 32'h8020_0003;
  localparam logic [31:0] SeedReset = 32'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FLUTTER_STEP  = 3'd0,
    REG_WOW_STEP      = 3'd1,
    REG_FLUTTER_DEPTH = 3'd2,
    REG_WOW_DEPTH     = 3'd3,
    REG_NOISE_LEVEL   = 3'd4,
    REG_CHANNEL_COUNT = 3'd5,
    REG_NOISE_SEED    = 3'd6
  } reg_index_e;

  typedef struct packed {
    logic step;
    logic load;
  } lfsr_ctrl_t;

  typedef logic [14:0] sine_rom_t [0:RomN];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] y;
    for (int k = 0; k <= RomN; k++) begin
      x  = 64'(k) << (30 - SineAddrBits);
      x2 = (x * x) >> 30;
      p  = 64'd172272;
      p  = 64'd5026995 - ((x2 * p) >> 30);
      p  = 64'd85569305 - ((x2 * p) >> 30);
      p  = 64'd693598668 - ((x2 * p) >> 30);
      p  = 64'd1686629713 - ((x2 * p) >> 30);
      y  = (x * p) >> 30;
      y  = (y + 64'd16384) >> 15;
      rom[k] = (y > 64'd32767) ? 15'h7fff : y[14:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

endpackage

### rtl/twf_sine.sv
// Quarter-wave sine lookup addressed by the top bits of a phase accumulator.
module twf_sine
  import twf_pkg::*;
(
  input  logic [PhaseBits-1:0] phase_i,
  output logic signed [15:0]   sine_o
);

  logic [SineAddrBits+1:0] top;
  logic [1:0]              quad;
  logic [SineAddrBits-1:0] idx;
  logic [SineAddrBits:0]   addr;
  logic [14:0]             mag;

  assign top  = phase_i[PhaseBits-1 -: SineAddrBits+2];
  assign quad = top[SineAddrBits+1:SineAddrBits];
  assign idx  = top[SineAddrBits-1:0];
  assign addr = quad[0] ? ((SineAddrBits+1)'(RomN) - {1'b0, idx}) : {1'b0, idx};
  assign mag  = SineRom[addr];
  assign sine_o = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

### rtl/twf_lfsr.sv
// 32-bit Galois noise generator with seed reload.
module twf_lfsr
  import twf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lfsr_ctrl_t  ctrl_i,
  input  logic [31:0] seed_i,
  output logic [31:0] state_o
);

  logic [31:0] lfsr_q;
  logic [31:0] lfsr_d;

  always_comb begin
    lfsr_d = lfsr_q;
    if (ctrl_i.load) begin
      lfsr_d = (seed_i == 32'd0) ? 32'd1 : seed_i;
    end else if (ctrl_i.step) begin
      lfsr_d = (lfsr_q >> 1) ^ (lfsr_q[0] ? LfsrTaps : 32'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= SeedReset;
    end else begin
      lfsr_q <= lfsr_d;
    end
  end

  assign state_o = lfsr_q;

endmodule

### rtl/twf_mul.sv
// Shared signed multiplier with a registered product.
module twf_mul
  import twf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [MulW-1:0]  a_i,
  input  logic signed [MulW-1:0]  b_i,
  output logic signed [ProdW-1:0] prod_o
);

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

### rtl/tape_wow_flutter_modulator_top.sv
// Top level of the tape wow and flutter modulator with its sequencer and datapath.
// A sample runs S_NOISE, S_SAMP, S_DONE, after S_FLUT, S_WOW at frame start, where
// flutter and wow sine terms are weighted to form the new frame gain; every product
// goes through one shared 18 by 18 bit multiplier with a registered output, one
// multiplication per cycle. A finished sample waits in the output register, so the
// next sample is accepted while it waits to be taken. Configuration writes take
// effect at once and must only be issued while the block is idle.
module tape_wow_flutter_modulator_top
  import twf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [DataW-1:0]   s_axis_tdata_i,   // sample_in
  input  logic               s_axis_tlast_i,   // end_of_block
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [DataW-1:0]   m_axis_tdata_o,   // sample_out
  output logic               m_axis_tuser_o,   // clipped
  output logic               m_axis_tlast_o,   // end_of_block_out
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FLUT  = 6'b000010,
    S_WOW   = 6'b000100,
    S_NOISE = 6'b001000,
    S_SAMP  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  localparam int SMax = (1 << (SampleBits - 1)) - 1;
  localparam int SMin = -(1 << (SampleBits - 1));
  localparam logic signed [AccW-1:0] AccMax  = AccW'(SMax);
  localparam logic signed [AccW-1:0] AccMin  = AccW'(SMin);
  localparam logic signed [SumW-1:0] GainMax = SumW'(131071);
  localparam logic signed [SumW-1:0] GainMin = SumW'(-131072);
  localparam logic signed [SumW-1:0] Unity   = SumW'(65536);

  state_e state_q, state_d;

  logic [PhaseBits-1:0] flutter_step_q, wow_step_q, flutter_phase_q, wow_phase_q;
  logic [15:0]          flutter_depth_q, wow_depth_q;
  logic [14:0]          noise_level_q;
  logic [CountW-1:0]    channel_count_q;
  logic [PosW-1:0]      pos_q;
  logic signed [GainW-1:0] frame_gain_q;

  logic signed [SampleBits-1:0] sample_q;
  logic                         eob_q;
  logic                         frame_start_q;
  logic signed [SumW-1:0]       gsum_q;
  logic signed [NoiseW-1:0]     noise_q;

  logic                  out_valid_q;
  logic [SampleBits-1:0] out_sample_q;
  logic                  out_clip_q, out_last_q;

  logic                    accept, out_free, load_out;
  logic [CountW-1:0]       count;
  logic [PhaseBits-1:0]    sine_phase;
  logic signed [15:0]      sine;
  logic [31:0]             lfsr;
  lfsr_ctrl_t              lfsr_ctrl;
  logic                    mul_en;
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [SumW-1:0]  term, gain_total;
  logic signed [AccW-1:0]  scaled, acc;
  logic                    clip;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign load_out        = (state_q == S_DONE) && out_free;

  assign count = (channel_count_q == '0) ? CountW'(1) :
                 (channel_count_q > CountW'(MaxChannels)) ? CountW'(MaxChannels) :
                 channel_count_q;

  assign sine_phase = (state_q == S_FLUT) ? flutter_phase_q : wow_phase_q;

  twf_sine u_sine (
    .phase_i (sine_phase),
    .sine_o  (sine)
  );

  assign lfsr_ctrl.step = accept;
  assign lfsr_ctrl.load = cfg_we_i && (cfg_index_i == REG_NOISE_SEED);

  twf_lfsr u_lfsr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lfsr_ctrl),
    .seed_i  (cfg_data_i[31:0]),
    .state_o (lfsr)
  );

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_FLUT: begin
        mul_a = $signed(MulW'(flutter_depth_q));
        mul_b = MulW'(sine);
      end
      S_WOW: begin
        mul_a = $signed(MulW'(wow_depth_q));
        mul_b = MulW'(sine);
      end
      S_NOISE: begin
        mul_a = MulW'($signed(lfsr[15:0]));
        mul_b = $signed(MulW'(noise_level_q));
      end
      S_SAMP: begin
        mul_a = MulW'(sample_q);
        mul_b = MulW'(frame_gain_q);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  twf_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign term       = SumW'((prod + ProdW'(16384)) >>> 15);
  assign gain_total = gsum_q + term;
  assign scaled     = AccW'((prod + ProdW'(32768)) >>> 16);
  assign acc        = scaled + AccW'(noise_q);
  assign clip       = (acc > AccMax) || (acc < AccMin);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = (pos_q == '0) ? S_FLUT : S_NOISE;
      S_FLUT:  state_d = S_WOW;
      S_WOW:   state_d = S_NOISE;
      S_NOISE: state_d = S_SAMP;
      S_SAMP:  state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      flutter_step_q  <= 32'd447392;
      wow_step_q      <= 32'd44739;
      flutter_depth_q <= 16'd197;
      wow_depth_q     <= 16'd131;
      noise_level_q   <= 15'd164;
      channel_count_q <= CountW'(2);
      flutter_phase_q <= '0;
      wow_phase_q     <= '0;
      pos_q           <= '0;
      frame_gain_q    <= GainW'(65536);
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FLUTTER_STEP:  flutter_step_q  <= cfg_data_i[PhaseBits-1:0];
          REG_WOW_STEP:      wow_step_q      <= cfg_data_i[PhaseBits-1:0];
          REG_FLUTTER_DEPTH: flutter_depth_q <= cfg_data_i[15:0];
          REG_WOW_DEPTH:     wow_depth_q     <= cfg_data_i[15:0];
          REG_NOISE_LEVEL:   noise_level_q   <= cfg_data_i[14:0];
          REG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        pos_q <= ((CountW'(pos_q) + CountW'(1)) >= count) ? '0 : pos_q + PosW'(1);
      end
      if ((state_q == S_NOISE) && frame_start_q) begin
        frame_gain_q    <= (gain_total > GainMax) ? GainW'(GainMax) :
                           (gain_total < GainMin) ? GainW'(GainMin) :
                           GainW'(gain_total);
        flutter_phase_q <= flutter_phase_q + flutter_step_q;
        wow_phase_q     <= wow_phase_q + wow_step_q;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q      <= $signed(s_axis_tdata_i[SampleBits-1:0]);
      eob_q         <= s_axis_tlast_i;
      frame_start_q <= (pos_q == '0);
    end
    if (state_q == S_WOW) begin
      gsum_q <= Unity + term;
    end
    if (state_q == S_SAMP) begin
      noise_q <= NoiseW'(prod >>> NoiseShift);
    end
    if (load_out) begin
      out_sample_q <= (acc > AccMax) ? SampleBits'(AccMax) :
                      (acc < AccMin) ? SampleBits'(AccMin) :
                      SampleBits'(acc);
      out_clip_q   <= clip;
      out_last_q   <= eob_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = DataW'(out_sample_q);
  assign m_axis_tuser_o  = out_clip_q;
  assign m_axis_tlast_o  = out_last_q;

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("Input was ready right after a transaction.");

  a_frame_start_gain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (pos_q == '0) |=> state_q == S_FLUT)
    else $error("Frame start did not compute a new gain.");

  a_done_delivers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_axis_tvalid_o)
    else $error("Finished sample was not presented.");

  a_clip_is_rail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      (out_sample_q == SampleBits'(AccMax)) || (out_sample_q == SampleBits'(AccMin)))
    else $error("Clipped sample is not at a rail.");

endmodule

### test/tb_top.sv
// Self-checking testbench for the tape wow and flutter modulator top level.
`timescale 1ns / 1ps

module tb_top;
  import twf_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam logic [CfgIdxW-1:0] RegUnmapped = 3'd7;
  localparam logic [31:0] HissTaps = 32'h8020_0003;
  localparam longint UnityGain = 65536;
  localparam longint GainMax = 131071;
  localparam longint GainMin = -131072;
  localparam longint SampleMax = (longint'(1) << (SampleBits - 1)) - 1;
  localparam longint SampleMin = -SampleMax - 1;

  typedef struct {
    logic [SampleBits-1:0] sample;
    logic                  clip;
    logic                  last;
  } mod_result_t;

  class modulator_predictor;
    logic [14:0]   sine_table [0:RomN];
    logic [31:0]   flutter_inc;
    logic [31:0]   wow_inc;
    logic [15:0]   flutter_amt;
    logic [15:0]   wow_amt;
    logic [14:0]   hiss_level;
    logic [3:0]    channels;
    logic [31:0]   flutter_ph;
    logic [31:0]   wow_ph;
    logic [31:0]   hiss_lfsr;
    logic [2:0]    chan_pos;
    longint        gain_q16;
    mod_result_t   pending_outputs [$];
    int            errors;

    function new();
      longint unsigned coef [5] = '{1686629713, 693598668, 85569305, 5026995, 172272};
      longint unsigned x;
      longint unsigned x2;
      longint unsigned p;
      longint unsigned y;
      for (int k = 0; k <= RomN; k++) begin
        x = longint'(k) << (30 - SineAddrBits);
        x2 = (x * x) >> 30;
        p = coef[4];
        for (int i = 3; i >= 0; i--) begin
          p = coef[i] - ((x2 * p) >> 30);
        end
        y = ((x * p) >> 30 + 0);
        y = (y + 16384) >> 15;
        sine_table[k] = (y > 32767) ? 15'h7fff : y[14:0];
      end
      flutter_inc = 32'd447392;
      wow_inc = 32'd44739;
      flutter_amt = 16'd197;
      wow_amt = 16'd131;
      hiss_level = 15'd164;
      channels = 4'd2;
      flutter_ph = '0;
      wow_ph = '0;
      hiss_lfsr = 32'd1;
      chan_pos = '0;
      gain_q16 = UnityGain;
      errors = 0;
    endfunction

    function longint round_half_up(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function int tone_of(logic [31:0] ph);
      logic [1:0]              quad;
      logic [SineAddrBits-1:0] idx;
      int                      v;
      quad = ph[PhaseBits-1 -: 2];
      idx = ph[PhaseBits-3 -: SineAddrBits];
      v = quad[0] ? int'(sine_table[RomN - idx]) : int'(sine_table[idx]);
      return quad[1] ? -v : v;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        REG_FLUTTER_STEP:  flutter_inc = val;
        REG_WOW_STEP:      wow_inc = val;
        REG_FLUTTER_DEPTH: flutter_amt = val[15:0];
        REG_WOW_DEPTH:     wow_amt = val[15:0];
        REG_NOISE_LEVEL:   hiss_level = val[14:0];
        REG_CHANNEL_COUNT: channels = val[3:0];
        REG_NOISE_SEED:    hiss_lfsr = (val == '0) ? 32'd1 : val;
        default: ;
      endcase
    endfunction

    function void accept_sample(logic [SampleBits-1:0] smp, logic last);
      longint      s;
      longint      g;
      longint      noise;
      longint      acc;
      int          cnt;
      mod_result_t r;
      s = longint'($signed(smp));
      cnt = int'(channels);
      if (cnt < 1) cnt = 1;
      if (cnt > MaxChannels) cnt = MaxChannels;
      if (chan_pos == '0) begin
        g = UnityGain + round_half_up(longint'(flutter_amt) * tone_of(flutter_ph), 15)
            + round_half_up(longint'(wow_amt) * tone_of(wow_ph), 15);
        if (g > GainMax) g = GainMax;
        if (g < GainMin) g = GainMin;
        gain_q16 = g;
        flutter_ph = flutter_ph + flutter_inc;
        wow_ph = wow_ph + wow_inc;
      end
      hiss_lfsr = hiss_lfsr[0] ? ((hiss_lfsr >> 1) ^ HissTaps) : (hiss_lfsr >> 1);
      noise = (longint'($signed(hiss_lfsr[15:0])) * longint'(hiss_level)) >>> (31 - SampleBits);
      acc = round_half_up(s * gain_q16, 16) + noise;
      r.clip = 1'b0;
      if (acc > SampleMax) begin
        acc = SampleMax;
        r.clip = 1'b1;
      end
      if (acc < SampleMin) begin
        acc = SampleMin;
        r.clip = 1'b1;
      end
      r.sample = acc[SampleBits-1:0];
      r.last = last;
      pending_outputs.push_back(r);
      if (int'(chan_pos) + 1 >= cnt) chan_pos = '0;
      else chan_pos = chan_pos + 3'd1;
    endfunction

    function void check_output(logic [SampleBits-1:0] smp, logic clip, logic last);
      mod_result_t want;
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected transaction, sample %h clip %b last %b",
                 $time, smp, clip, last);
        errors++;
        return;
      end
      want = pending_outputs.pop_front();
      if (want.sample !== smp) begin
        $display("%0t: sample_out expected %h actual %h", $time, want.sample, smp);
        errors++;
      end
      if (want.clip !== clip) begin
        $display("%0t: clipped expected %b actual %b", $time, want.clip, clip);
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: end_of_block_out expected %b actual %b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [DataW-1:0]   s_axis_tdata_i;
  logic               s_axis_tlast_i;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [DataW-1:0]   m_axis_tdata_o;
  logic               m_axis_tuser_o;
  logic               m_axis_tlast_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;

  modulator_predictor predictor;
  int                 burst_left = 0;
  bit                 long_hold_req = 1'b0;

  tape_wow_flutter_modulator_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_sample(input logic [SampleBits-1:0] smp, input logic last);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= DataW'(smp);
    s_axis_tlast_i <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predictor.accept_sample(smp, last);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = $urandom_range(1, 10);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    predictor.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (predictor.pending_outputs.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value(int unsigned bits);
    logic [31:0] ones;
    ones = (bits >= 32) ? 32'hffff_ffff : ((32'd1 << bits) - 32'd1);
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return ones;
      2: return $urandom_range(0, 255);
      default: return $urandom() & ones;
    endcase
  endfunction

  function automatic logic [SampleBits-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return SampleBits'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_settings();
    if ($urandom_range(0, 3) != 0) write_reg(REG_FLUTTER_STEP, pick_value(32));
    if ($urandom_range(0, 3) != 0) write_reg(REG_WOW_STEP, pick_value(32));
    if ($urandom_range(0, 3) != 0) write_reg(REG_FLUTTER_DEPTH, pick_value(16));
    if ($urandom_range(0, 3) != 0) write_reg(REG_WOW_DEPTH, pick_value(16));
    if ($urandom_range(0, 3) != 0) write_reg(REG_NOISE_LEVEL, pick_value(15));
    if ($urandom_range(0, 3) != 0) begin
      write_reg(REG_CHANNEL_COUNT, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                              : $urandom_range(1, 8));
    end
    if ($urandom_range(0, 3) == 0) write_reg(REG_NOISE_SEED, pick_value(32));
    if ($urandom_range(0, 5) == 0) write_reg(RegUnmapped, $urandom());
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      predictor.check_output(m_axis_tdata_o[SampleBits-1:0], m_axis_tuser_o, m_axis_tlast_o);
    end
  end

  initial begin : receiver
    int mode;
    int left;
    int hold;
    m_axis_tready_i <= 1'b0;
    mode = 0;
    left = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 300;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      if (hold > 0) begin
        hold--;
        m_axis_tready_i <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= ($urandom_range(0, 1) == 1);
          2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tape_wow_flutter_modulator_top test failed");
    $finish;
  end

  initial begin : stimulus
    logic [SampleBits-1:0] corner_values [7] = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001,
                                                 16'hffff, 16'h5555, 16'haaaa};
    rst_ni <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    s_axis_tlast_i <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= REG_FLUTTER_STEP;
    cfg_data_i <= '0;
    predictor = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings first, then extreme depths, zero channel count and zero seed.
    for (int i = 0; i < 7; i++) send_sample(corner_values[i], i[0]);
    wait_idle();
    write_reg(REG_FLUTTER_STEP, 32'hffff_ffff);
    write_reg(REG_WOW_STEP, 32'h8000_0000);
    write_reg(REG_FLUTTER_DEPTH, 32'h0000_ffff);
    write_reg(REG_WOW_DEPTH, 32'h0000_ffff);
    write_reg(REG_NOISE_LEVEL, 32'h0000_7fff);
    write_reg(REG_CHANNEL_COUNT, 32'd0);
    write_reg(REG_NOISE_SEED, 32'd0);
    write_reg(RegUnmapped, 32'h1234_5678);
    for (int i = 0; i < 6; i++) send_sample(corner_values[i], i[0]);
    wait_idle();

    // Oversized channel count with unity gain, then the count is lowered mid-frame.
    write_reg(REG_CHANNEL_COUNT, 32'd15);
    write_reg(REG_NOISE_SEED, 32'hffff_ffff);
    write_reg(REG_FLUTTER_DEPTH, 32'd0);
    write_reg(REG_WOW_DEPTH, 32'd0);
    write_reg(REG_NOISE_LEVEL, 32'd0);
    for (int i = 0; i < 10; i++) send_sample(corner_values[i % 7], (i == 9));
    wait_idle();
    write_reg(REG_CHANNEL_COUNT, 32'd2);
    for (int i = 0; i < 3; i++) send_sample(corner_values[i + 4], i[0]);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      random_settings();
      if (p == 2) long_hold_req = 1'b1;
      repeat (66) send_sample(random_sample(), ($urandom_range(0, 7) == 0));
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (predictor.errors == 0) begin
      $display("tape_wow_flutter_modulator_top test passed");
    end else begin
      $display("tape_wow_flutter_modulator_top test failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/twf_pkg.sv
rtl/twf_sine.sv
rtl/twf_lfsr.sv
rtl/twf_mul.sv
rtl/tape_wow_flutter_modulator_top.sv
test/tb_top.sv
